// ===== rtl/spsl_pkg.sv =====
package spsl_pkg;

	// pulse range of the output channel
	localparam int PULSE_LOW  = 150;
	localparam int PULSE_HIGH = 600;
	localparam int SPAN       = PULSE_HIGH - PULSE_LOW;

	// angle scale
	localparam int ANGLE_FULL = 180;
	localparam int ANGLE_HALF = 90;

	// field widths
	localparam int PULSE_W = 12;
	localparam int ANG_W   = 8;
	localparam int RATE_W  = 16;
	localparam int TIME_W  = 32;

	// angle times span
	localparam int PROD_W = ANG_W + PULSE_W;
	// signed working width for pulse sums
	localparam int WORK_W = 16;

	// serial divider sizes
	localparam int DIV_W = 32;
	localparam int DVR_W = RATE_W + 1;

	// register port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_MIN_ANGLE   = 3'd0,
		REG_MAX_ANGLE   = 3'd1,
		REG_TRIM_ANGLE  = 3'd2,
		REG_REVERSE_OFF = 3'd3,
		REG_MS_PER_STEP = 3'd4
	} reg_idx_t;

	typedef enum logic {
		OP_SET_TARGET = 1'b0,
		OP_UPDATE     = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRIM,
		ST_TRIM_W,
		ST_LO,
		ST_LO_W,
		ST_HI,
		ST_HI_W,
		ST_TGT,
		ST_TGT_W,
		ST_UPD,
		ST_UPD_W,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/servo_pulse_slew_limiter_top.sv =====
// Set-target request: four serial divisions in turn (trim, lower limit, upper limit,
// target), then the result is registered.
// Update request while moving: one 32-step division of elapsed time.
// Update request at target: no division. One request in flight at a time;
// the next is taken as soon as the result is registered. Reset: pulse and target at
// mid range, time stamp zero, registers at their defaults.
module servo_pulse_slew_limiter_top import spsl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [ANG_W-1:0]   angle,
	input  logic [TIME_W-1:0]  now_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [PULSE_W-1:0] pulse,
	output logic               moving,
	output logic               pulse_written,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	localparam logic signed [WORK_W-1:0] LOW_S    = WORK_W'(PULSE_LOW);
	localparam logic signed [WORK_W-1:0] HIGH_S   = WORK_W'(PULSE_HIGH);
	localparam logic signed [ANG_W-1:0]  TRIM_MAX = ANG_W'(ANGLE_HALF);
	localparam logic signed [ANG_W-1:0]  TRIM_MIN = -TRIM_MAX;
	localparam int                       LIM_BASE = PULSE_LOW * ANGLE_FULL;
	localparam logic [PULSE_W-1:0]       MID      = PULSE_W'((PULSE_LOW + PULSE_HIGH) / 2);

	function automatic logic signed [WORK_W-1:0] clamp_s(
		input logic signed [WORK_W-1:0] x,
		input logic signed [WORK_W-1:0] lo,
		input logic signed [WORK_W-1:0] hi
	);
		if (x < lo)
			return lo;
		if (x > hi)
			return hi;
		return x;
	endfunction

	// configuration registers
	logic [ANG_W-1:0]         min_angle_q;
	logic [ANG_W-1:0]         max_angle_q;
	logic signed [ANG_W-1:0]  trim_angle_q;
	logic                     reverse_off_q;
	logic [RATE_W-1:0]        ms_per_step_q;

	// state
	state_t                   state_q, state_d;
	logic [PULSE_W-1:0]       cur_q;
	logic [PULSE_W-1:0]       tgt_q;
	logic [TIME_W-1:0]        last_q;

	// request and intermediate values
	logic [ANG_W-1:0]         ang_q;
	logic [TIME_W-1:0]        now_q;
	logic signed [WORK_W-1:0] trim_q;
	logic [PULSE_W-1:0]       lo_q;
	logic [PULSE_W-1:0]       hi_q;
	logic                     wr_q;

	// result register
	logic                     out_valid_q;
	logic [PULSE_W-1:0]       out_pulse_q;
	logic                     out_moving_q;
	logic                     out_written_q;

	logic                     cfg_wr;
	logic                     in_acc;
	logic                     div_start;
	logic                     div_done;
	logic [DIV_W-1:0]         div_dividend;
	logic [DVR_W-1:0]         div_divisor;
	logic [DIV_W-1:0]         div_quot;
	logic                     ld_trim, ld_lo, ld_hi, ld_tgt, ld_cur, ld_last, wr_set;
	logic                     res_load;

	logic signed [ANG_W-1:0]  trim_c;
	logic                     trim_neg;
	logic [ANG_W-1:0]         trim_mag;
	logic                     rev_gt;
	logic [ANG_W-1:0]         rev_mag;
	logic [ANG_W-1:0]         mul_op;
	logic [PROD_W-1:0]        prod;
	logic [PROD_W:0]          lim_num;
	logic [RATE_W-1:0]        rate;
	logic signed [WORK_W-1:0] q_w;
	logic signed [WORK_W-1:0] trim_new;
	logic [PULSE_W-1:0]       lim_new;
	logic signed [WORK_W-1:0] t_base;
	logic [PULSE_W-1:0]       tgt_new;
	logic                     up;
	logic [PULSE_W-1:0]       remain;
	logic                     reach;
	logic [PULSE_W-1:0]       np;
	logic [PULSE_W-1:0]       np_c;

	spsl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_angle_q   <= '0;
			max_angle_q   <= ANG_W'(ANGLE_FULL);
			trim_angle_q  <= '0;
			reverse_off_q <= 1'b1;
			ms_per_step_q <= RATE_W'(1);
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_MIN_ANGLE:   min_angle_q   <= pwdata[ANG_W-1:0];
				REG_MAX_ANGLE:   max_angle_q   <= pwdata[ANG_W-1:0];
				REG_TRIM_ANGLE:  trim_angle_q  <= pwdata[ANG_W-1:0];
				REG_REVERSE_OFF: reverse_off_q <= pwdata[0];
				REG_MS_PER_STEP: ms_per_step_q <= pwdata[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_MIN_ANGLE:   prdata = DATA_W'(min_angle_q);
			REG_MAX_ANGLE:   prdata = DATA_W'(max_angle_q);
			REG_TRIM_ANGLE:  prdata = DATA_W'(unsigned'(trim_angle_q));
			REG_REVERSE_OFF: prdata = DATA_W'(reverse_off_q);
			REG_MS_PER_STEP: prdata = DATA_W'(ms_per_step_q);
			default:         prdata = '0;
		endcase
	end

	// handshake
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign pulse         = out_pulse_q;
	assign moving        = out_moving_q;
	assign pulse_written = out_written_q;

	// trim clamped to plus or minus a quarter turn, split into sign and magnitude
	assign trim_c   = (trim_angle_q < TRIM_MIN) ? TRIM_MIN :
		((trim_angle_q > TRIM_MAX) ? TRIM_MAX : trim_angle_q);
	assign trim_neg = trim_c[ANG_W-1];
	assign trim_mag = trim_neg ? ANG_W'(-trim_c) : ANG_W'(trim_c);

	// distance from the far end for reversed mapping
	assign rev_gt  = ang_q > ANG_W'(ANGLE_FULL);
	assign rev_mag = rev_gt ? ang_q - ANG_W'(ANGLE_FULL) : ANG_W'(ANGLE_FULL) - ang_q;

	assign prod    = PROD_W'(mul_op) * PROD_W'(SPAN);
	assign lim_num = (PROD_W + 1)'(prod) + (PROD_W + 1)'(LIM_BASE);
	assign rate    = (ms_per_step_q == '0) ? RATE_W'(1) : ms_per_step_q;

	// quotient post-processing
	assign q_w      = signed'(div_quot[WORK_W-1:0]);
	assign trim_new = trim_neg ? -q_w : q_w;
	assign lim_new  = PULSE_W'(clamp_s(q_w + trim_q, LOW_S, HIGH_S));
	assign t_base   = (!reverse_off_q && rev_gt) ? LOW_S - q_w : LOW_S + q_w;
	assign tgt_new  = PULSE_W'(clamp_s(t_base + trim_q,
		signed'(WORK_W'(lo_q)), signed'(WORK_W'(hi_q))));

	// step toward the target, landing on it when the step count reaches it
	assign up     = tgt_q > cur_q;
	assign remain = up ? tgt_q - cur_q : cur_q - tgt_q;
	assign reach  = div_quot >= DIV_W'(remain);
	assign np     = reach ? tgt_q :
		(up ? cur_q + div_quot[PULSE_W-1:0] : cur_q - div_quot[PULSE_W-1:0]);
	assign np_c   = (np < PULSE_W'(PULSE_LOW)) ? PULSE_W'(PULSE_LOW) :
		((np > PULSE_W'(PULSE_HIGH)) ? PULSE_W'(PULSE_HIGH) : np);

	// sequencer
	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		mul_op       = '0;
		ld_trim      = 1'b0;
		ld_lo        = 1'b0;
		ld_hi        = 1'b0;
		ld_tgt       = 1'b0;
		ld_cur       = 1'b0;
		ld_last      = 1'b0;
		wr_set       = 1'b0;
		res_load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = (op_t'(operation) == OP_SET_TARGET) ? ST_TRIM : ST_UPD;
			end
			ST_TRIM: begin
				mul_op       = trim_mag;
				div_dividend = DIV_W'({prod, 1'b0}) + DIV_W'(ANGLE_HALF);
				div_divisor  = DVR_W'(2 * ANGLE_HALF);
				div_start    = 1'b1;
				state_d      = ST_TRIM_W;
			end
			ST_TRIM_W: begin
				if (div_done) begin
					ld_trim = 1'b1;
					state_d = ST_LO;
				end
			end
			ST_LO: begin
				mul_op       = min_angle_q;
				div_dividend = DIV_W'({lim_num, 1'b0}) + DIV_W'(ANGLE_FULL);
				div_divisor  = DVR_W'(2 * ANGLE_FULL);
				div_start    = 1'b1;
				state_d      = ST_LO_W;
			end
			ST_LO_W: begin
				if (div_done) begin
					ld_lo   = 1'b1;
					state_d = ST_HI;
				end
			end
			ST_HI: begin
				mul_op       = max_angle_q;
				div_dividend = DIV_W'({lim_num, 1'b0}) + DIV_W'(ANGLE_FULL);
				div_divisor  = DVR_W'(2 * ANGLE_FULL);
				div_start    = 1'b1;
				state_d      = ST_HI_W;
			end
			ST_HI_W: begin
				if (div_done) begin
					ld_hi   = 1'b1;
					state_d = ST_TGT;
				end
			end
			ST_TGT: begin
				mul_op       = reverse_off_q ? ang_q : rev_mag;
				div_dividend = DIV_W'(prod);
				div_divisor  = DVR_W'(ANGLE_FULL);
				div_start    = 1'b1;
				state_d      = ST_TGT_W;
			end
			ST_TGT_W: begin
				if (div_done) begin
					ld_tgt  = 1'b1;
					ld_last = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_UPD: begin
				if (cur_q == tgt_q) begin
					ld_last = 1'b1;
					state_d = ST_DONE;
				end else begin
					div_dividend = now_q - last_q;
					div_divisor  = DVR_W'(rate);
					div_start    = 1'b1;
					state_d      = ST_UPD_W;
				end
			end
			ST_UPD_W: begin
				if (div_done) begin
					// no whole step elapsed: keep pulse and time stamp
					if (div_quot != '0) begin
						ld_cur  = 1'b1;
						ld_last = 1'b1;
						wr_set  = 1'b1;
					end
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// servo state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= MID;
			tgt_q  <= MID;
			last_q <= '0;
		end else begin
			if (ld_cur)
				cur_q <= np_c;
			if (ld_tgt)
				tgt_q <= tgt_new;
			if (ld_last)
				last_q <= now_q;
		end
	end

	// request capture and intermediate results
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ang_q <= angle;
			now_q <= now_ms;
			wr_q  <= 1'b0;
		end else if (wr_set) begin
			wr_q <= 1'b1;
		end
		if (ld_trim)
			trim_q <= trim_new;
		if (ld_lo)
			lo_q <= lim_new;
		if (ld_hi)
			hi_q <= lim_new;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_pulse_q   <= cur_q;
			out_moving_q  <= (cur_q != tgt_q);
			out_written_q <= wr_q;
		end
	end

	a_pulse_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q >= PULSE_W'(PULSE_LOW) && cur_q <= PULSE_W'(PULSE_HIGH))
		else $error("current pulse left the pulse range");

	a_write_moves: assert property (@(posedge clk) disable iff (!arst_n)
		ld_cur |=> cur_q != $past(cur_q))
		else $error("pulse write without movement");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_TRIM_W || state_q == ST_LO_W || state_q == ST_HI_W ||
			state_q == ST_TGT_W || state_q == ST_UPD_W))
		else $error("divider finished outside a wait state");

endmodule

// ===== rtl/spsl_div.sv =====
module spsl_div import spsl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVR_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_W);

	logic [DIV_W-1:0] dq_q;
	logic [DVR_W-1:0] rem_q;
	logic [DVR_W-1:0] dvr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVR_W:0]   rem_sh;
	logic [DVR_W:0]   rem_sub;
	logic             ge;

	// one restoring step: bring down the next dividend bit
	assign rem_sh  = {rem_q, dq_q[DIV_W-1]};
	assign ge      = rem_sh >= {1'b0, dvr_q};
	assign rem_sub = rem_sh - {1'b0, dvr_q};

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvr_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DIV_W-2:0], ge};
			rem_q <= ge ? rem_sub[DVR_W-1:0] : rem_sh[DVR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start && cnt_q == '0) |=> (done_q && !busy_q))
		else $error("divider missed its done pulse");

endmodule
